// File: rtl/serial_command_parser_queue_core_macros.svh
// Assertion macros shared by the command parser queue RTL.
`ifndef SERIAL_COMMAND_PARSER_QUEUE_CORE_MACROS_SVH
`define SERIAL_COMMAND_PARSER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SCPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SCPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/scpq_pkg.sv
// Types and constants shared by the command parser queue modules.
package scpq_pkg;

   // Parser phases
   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_READ_ADDR  = 2'd1,
      PH_WRITE_ADDR = 2'd2,
      PH_WRITE_VAL  = 2'd3
   } phase_type;

   // Command kinds as reported on the result channel
   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Command opening characters
   localparam logic [7:0] CHAR_READ   = 8'h3F;  // '?'
   localparam logic [7:0] CHAR_WRITE  = 8'h3D;  // '='
   localparam logic [7:0] CHAR_STATUS = 8'h23;  // '#'

   // Item operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Width of the reported queue count
   localparam int unsigned CountOutW = 6;

   // One queued command: kind on top, then address, then value
   typedef struct packed {
      kind_type   kind;
      logic [7:0] address;
      logic [7:0] value;
   } entry_type;

   // Push request from the parser to the queue
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Per-item status from the queue
   typedef struct packed {
      logic pop_ok;
      logic dropped;
   } qstat_type;

endpackage

// File: rtl/scpq_parser.sv
// Byte parser that turns received characters into command push requests.
module scpq_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output scpq_pkg::push_type push
);
   import scpq_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] pend_addr_ff, pend_addr_in;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               priority if (rx_byte == CHAR_READ) begin
                  phase_in = PH_READ_ADDR;
               end else if (rx_byte == CHAR_WRITE) begin
                  phase_in = PH_WRITE_ADDR;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_READ_ADDR:  phase_in = PH_IDLE;
            PH_WRITE_ADDR: phase_in = PH_WRITE_VAL;
            PH_WRITE_VAL:  phase_in = PH_IDLE;
            default:       phase_in = PH_IDLE;
         endcase
      end
   end

   // Capture the address of a write in progress
   assign pend_addr_in = (step && phase_ff == PH_WRITE_ADDR) ? rx_byte : pend_addr_ff;

   // Push request for a completed command
   always_comb begin
      push = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            push.push          = step && (rx_byte == CHAR_STATUS);
            push.entry.kind    = KIND_STATUS;
         end
         PH_READ_ADDR: begin
            push.push          = step;
            push.entry.kind    = KIND_READ;
            push.entry.address = rx_byte;
         end
         PH_WRITE_ADDR: begin
            push.push          = 1'b0;
         end
         PH_WRITE_VAL: begin
            push.push          = step;
            push.entry.kind    = KIND_WRITE;
            push.entry.address = pend_addr_ff;
            push.entry.value   = rx_byte;
         end
         default: begin
            push.push          = 1'b0;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pend_addr_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         pend_addr_ff <= pend_addr_in;
      end
   end

endmodule

// File: rtl/scpq_queue.sv
// Ring queue of commands held in a synchronous memory.
`include "serial_command_parser_queue_core_macros.svh"

module scpq_queue #(
   parameter int unsigned QUEUE_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  scpq_pkg::push_type                 push,
   input  logic                               pop,
   output scpq_pkg::qstat_type                stat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_next,
   output scpq_pkg::entry_type                rd_entry
);
   import scpq_pkg::*;

   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
   localparam int unsigned SumW = CntW + 1;

   logic [IdxW-1:0] head_ff, head_in, head_inc;
   logic [CntW-1:0] count_ff, count_in;
   logic [SumW-1:0] tail_sum, tail_wrap;
   logic [IdxW-1:0] tail;
   logic            full, empty, wr_en, pop_ok;
   entry_type       mem [QUEUE_DEPTH];
   entry_type       rd_entry_ff;

   // Occupancy and request qualification
   assign full   = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign wr_en  = push.push && !full;
   assign pop_ok = pop && !empty;

   // Tail position: head plus count, wrapped once
   assign tail_sum  = SumW'(head_ff) + SumW'(count_ff);
   assign tail_wrap = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                      (tail_sum - SumW'(QUEUE_DEPTH)) : tail_sum;
   assign tail      = tail_wrap[IdxW-1:0];

   // Advance head and count
   assign head_inc = (head_ff == IdxW'(QUEUE_DEPTH - 1)) ? '0 : (head_ff + IdxW'(1));
   assign head_in  = pop_ok ? head_inc : head_ff;

   always_comb begin
      priority if (pop_ok) begin
         count_in = count_ff - CntW'(1);
      end else if (wr_en) begin
         count_in = count_ff + CntW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign count_next   = count_in;
   assign stat.pop_ok  = pop_ok;
   assign stat.dropped = push.push && full;
   assign rd_entry     = rd_entry_ff;

   // Pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Command memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail] <= push.entry;
      end
      if (pop) begin
         rd_entry_ff <= mem[head_ff];
      end
   end

   `SCPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QUEUE_DEPTH), "queue count above depth")
   `SCPQ_ASSERT_IMP(a_drop_full, clock, reset, stat.dropped, count_ff == CntW'(QUEUE_DEPTH), "drop while not full")
   `SCPQ_ASSERT_NXT(a_empty_pop, clock, reset, pop && empty && !push.push, $stable(head_ff) && count_ff == '0, "empty pop moved the queue")
   `SCPQ_ASSERT_NXT(a_push_count, clock, reset, wr_en, count_ff != '0, "push left the queue empty")

endmodule

// File: rtl/serial_command_parser_queue_core.sv
// Top level of the serial command parser with its command queue.
//
// Each request item is either a received serial byte (req_tuser = 0) or a pop of the oldest
// queued command (req_tuser = 1); every item yields exactly one response item. The block
// takes one item per cycle at full rate while the response side is not stalled. After
// acceptance, the head entry is read from the command memory at the accept edge, and the
// result is then moved into the response register. A one-item stage between the memory
// read and the response register lets a new request enter while a response waits to be
// taken. The command memory needs no clearing after reset.
`include "serial_command_parser_queue_core_macros.svh"

module serial_command_parser_queue_core #(
   parameter int unsigned QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] cmd_address, [15:8] cmd_value, [16] dropped,
                                    // [22:17] queue_count, [23] zero
   output logic [2:0]  rsp_tuser    // [0] cmd_valid, [2:1] cmd_kind
);
   import scpq_pkg::*;

   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   logic            accept, out_free, s1_adv;
   logic            byte_step, pop_step;
   push_type        push;
   qstat_type       stat;
   logic [CntW-1:0] count_next;
   entry_type       rd_entry;

   logic            s1_valid_ff, s1_valid_in;
   qstat_type       s1_stat_ff;
   logic [CntW-1:0] s1_count_ff;
   logic [CntW+CountOutW-1:0] s1_count_wide;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [23:0]     rsp_data_ff;
   logic [2:0]      rsp_user_ff;
   entry_type       res_entry;

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign byte_step  = accept && (req_tuser[0] == OP_BYTE);
   assign pop_step   = accept && (req_tuser[0] == OP_POP);

   scpq_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (byte_step),
      .rx_byte (req_tdata),
      .push    (push)
   );

   scpq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop_step),
      .stat       (stat),
      .count_next (count_next),
      .rd_entry   (rd_entry)
   );

   // Stage after the memory read
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff  <= stat;
         s1_count_ff <= count_next;
      end
   end

   // Form the response command fields: zeros unless a command was popped
   assign res_entry     = s1_stat_ff.pop_ok ? rd_entry : '0;
   assign s1_count_wide = {{CountOutW{1'b0}}, s1_count_ff};

   // Response register
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= {1'b0, s1_count_wide[CountOutW-1:0], s1_stat_ff.dropped,
                         res_entry.value, res_entry.address};
         rsp_user_ff <= {res_entry.kind, s1_stat_ff.pop_ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `SCPQ_ASSERT_NXT(a_accept_stage, clock, reset, accept, s1_valid_ff, "accepted item not staged")
   `SCPQ_ASSERT_NXT(a_stage_hold, clock, reset, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_count_ff), "stalled stage changed")
   `SCPQ_ASSERT_IMP(a_pop_no_drop, clock, reset, rsp_valid_ff && rsp_user_ff[0], !rsp_data_ff[16], "popped command flagged as dropped")
   `SCPQ_ASSERT_IMP(a_idle_zero, clock, reset, rsp_valid_ff && !rsp_user_ff[0], rsp_user_ff[2:1] == 2'b00 && rsp_data_ff[15:0] == 16'h0000, "empty response carries command fields")

endmodule
